@@ rtl/b32kd_pkg.sv @@
`default_nettype none
package b32kd_pkg;

  // Status codes on the result channel
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_INVALID  = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_SHORT    = 2'd3
  } status_t;

  localparam logic [7:0] SYM_NONE = 8'h00;  // empty item, end only
  localparam logic [7:0] PAD_CHAR = 8'h3D;  // '='

  // Decoder state carried from item to item
  typedef struct packed {
    logic [11:0] bit_buffer;
    logic [3:0]  bit_count;
    logic [5:0]  bytes_out;
    logic        pad_seen;
    status_t     error_code;
  } dec_state_t;

  // One result item
  typedef struct packed {
    logic       byte_valid;
    logic [7:0] key_byte;
    logic [4:0] byte_index;
    logic       done_res;
    status_t    status;
  } dec_result_t;

  // Alphabet lookup: {legal, 5-bit value}
  function automatic logic [5:0] sym_decode(input logic [7:0] c);
    logic [5:0] r;
    r = 6'd0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = {1'b1, 5'(c - 8'h41)};
    end else if (c >= 8'h32 && c <= 8'h37) begin
      r = {1'b1, 5'(c - 8'h32 + 8'd26)};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ rtl/b32kd_step.sv @@
`default_nettype none
module b32kd_step
  import b32kd_pkg::*;
#(
  parameter int KEY_BYTES   = 32,
  parameter int MAX_DECODED = 36
) (
  input  dec_state_t  st,
  input  logic [7:0]  symbol,
  input  logic        last,
  output dec_state_t  st_next,
  output dec_result_t res
);

  localparam logic [6:0] KEY_LIM = 7'(KEY_BYTES);
  localparam logic [6:0] MAX_LIM = 7'(MAX_DECODED);

  logic [5:0]  dec;
  logic [11:0] buf_w;
  logic [4:0]  cnt_w;
  logic [2:0]  sh;

  assign dec   = sym_decode(symbol);
  assign buf_w = {st.bit_buffer[6:0], dec[4:0]};
  assign cnt_w = {1'b0, st.bit_count} + 5'd5;
  // after taking a byte at most 4 bits remain
  assign sh    = 3'(cnt_w - 5'd8);

  // One character: pad, error, or shift in five bits and maybe emit a byte
  always_comb begin
    st_next        = st;
    res            = '0;
    res.done_res   = last;
    if (symbol != SYM_NONE && st.error_code == ST_OK) begin
      if (symbol == PAD_CHAR) begin
        st_next.pad_seen = 1'b1;
      end else if (!dec[5] || st.pad_seen) begin
        st_next.error_code = ST_INVALID;
      end else begin
        st_next.bit_buffer = buf_w;
        st_next.bit_count  = cnt_w[3:0];
        if (cnt_w >= 5'd8) begin
          st_next.bit_count = {1'b0, sh};
          if ({1'b0, st.bytes_out} >= MAX_LIM) begin
            st_next.error_code = ST_OVERFLOW;
          end else begin
            if ({1'b0, st.bytes_out} < KEY_LIM) begin
              res.byte_valid = 1'b1;
              res.key_byte   = 8'(buf_w >> sh);
              res.byte_index = st.bytes_out[4:0];
            end
            st_next.bytes_out = st.bytes_out + 6'd1;
          end
        end
      end
    end
    // final status on the last item
    res.status = st_next.error_code;
    if (last) begin
      if (st_next.error_code == ST_OK && {1'b0, st_next.bytes_out} < KEY_LIM) begin
        res.status = ST_SHORT;
      end
      st_next = '0;
    end
  end

endmodule
`default_nettype wire

@@ rtl/base32_key_decoder.sv @@
// Streaming base32 key decoder.
// Input channel s_*: one ASCII character per item in s_tdata[7:0]; s_tlast
// marks the final character of an address. A zero character is an empty
// item that only carries the end mark.
// Output channel m_*: exactly one result item per input item, in order.
// m_tdata holds byte_valid, key_byte, byte_index and status; m_tlast is
// done_res. Only the first KEY_BYTES decoded bytes come out with
// byte_valid set; status on the last item is the final verdict and the
// consumer drops the key unless it is ok.
// A result passes through one input register and one result register,
// with the decode step between them.
// Throughput: one item per cycle while the receiver takes results; the
// state update is a single shift-and-compare step, so items follow back to back.
// When the receiver stalls, the result register holds and the input
// register fills; s_tready falls once both are occupied.
// Reset clears the decoder state and empties both registers. After a last
// item the state returns to its reset value for the next address.
`default_nettype none
module base32_key_decoder
  import b32kd_pkg::*;
#(
  parameter int KEY_BYTES   = 32,
  parameter int MAX_DECODED = 36
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] symbol
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [0] byte_valid, [8:1] key_byte, [13:9] byte_index,
                                 // [15:14] status
  output logic        m_tlast
);

  logic        s1_valid;
  logic [7:0]  s1_symbol;
  logic        s1_last;
  logic        advance;
  dec_state_t  st;
  dec_state_t  st_next;
  dec_result_t res;

  assign advance  = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !s1_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1_symbol <= s_tdata;
      s1_last   <= s_tlast;
    end
  end

  b32kd_step #(
    .KEY_BYTES  (KEY_BYTES),
    .MAX_DECODED(MAX_DECODED)
  ) u_step (
    .st     (st),
    .symbol (s1_symbol),
    .last   (s1_last),
    .st_next(st_next),
    .res    (res)
  );

  // Decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {res.status, res.byte_index, res.key_byte, res.byte_valid};
      m_tlast <= res.done_res;
    end
  end

`ifndef SYNTHESIS
  // a delivered byte carries ok status, or too short on the last result
  a_byte_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |->
      m_tdata[15:14] == ST_OK || (m_tlast && m_tdata[15:14] == ST_SHORT))
    else $error("byte delivered with error status");

  // too short only on the last result
  a_short_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> m_tdata[15:14] != ST_SHORT)
    else $error("too-short status before end");

  // state is back to reset after a last item
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    advance && s1_last |=> st == '0)
    else $error("state not cleared after last item");

  // at rest fewer than eight bits are held
  a_bit_count: assert property (@(posedge clk) disable iff (rst)
    st.bit_count < 4'd8)
    else $error("bit count out of range");

  // no byte index beyond the key length
  a_index: assert property (@(posedge clk) disable iff (rst)
    advance && res.byte_valid |-> {1'b0, st.bytes_out} < 7'(KEY_BYTES))
    else $error("byte index beyond key");
`endif

endmodule
`default_nettype wire

@@ bench/testbench.sv @@
`default_nettype none
module testbench;
  import b32kd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int KEY_LEN    = 32;
  localparam int MAX_DEC    = 36;
  localparam int STALL_LIMIT = 2000;  // cycles with no item moving
  localparam int HOLD_CYCLES = 300;   // long receiver hold-off
  localparam int PHASE_ITEMS = 115;

  localparam logic [7:0] CH_A = 8'h41;
  localparam logic [7:0] CH_Z = 8'h5A;
  localparam logic [7:0] CH_2 = 8'h32;
  localparam logic [7:0] CH_7 = 8'h37;

  // Idle modes, one per phase
  typedef enum int {
    IDLE_NONE   = 0,
    IDLE_SENDER = 1,
    IDLE_RECV   = 2,
    IDLE_BOTH   = 3
  } idle_mode_t;

  typedef struct {
    logic [7:0] sym;
    logic       last;
  } char_item_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;   // [7:0] symbol
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;           // [0] byte_valid, [8:1] key_byte, [13:9] byte_index,
                                  // [15:14] status
  logic        m_tlast;

  base32_key_decoder #(
    .KEY_BYTES  (KEY_LEN),
    .MAX_DECODED(MAX_DEC)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tlast (s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
  );

  char_item_t  char_queue[$];     // characters waiting to be sent
  dec_result_t decoded_queue[$];  // predicted results, oldest first
  idle_mode_t  idle_mode = IDLE_NONE;
  int          fail_count = 0;
  int          chars_taken = 0;
  int          phase_items = 0;
  int          hold_left = 0;
  logic        hold_done = 1'b0;
  int          quiet_cycles = 0;

  // Decoder shadow state
  logic [11:0] sh_buf = '0;
  logic [3:0]  sh_cnt = '0;
  logic [5:0]  sh_bytes = '0;
  logic        sh_pad = 1'b0;
  status_t     sh_err = ST_OK;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic log_failure(input string what);
    fail_count++;
    if (fail_count <= 10) $display("ERROR: %s", what);
  endtask

  // Decode one character into the shadow state and form its result
  task automatic decode_char(input logic [7:0] sym, input logic lst, output dec_result_t r);
    logic       legal;
    logic [4:0] val;
    logic [11:0] nbuf;
    logic [4:0] ncnt;
    logic [11:0] shifted;
    r = '0;
    legal = 1'b0;
    val = '0;
    if (sym != SYM_NONE && sh_err == ST_OK) begin
      if (sym == PAD_CHAR) begin
        sh_pad = 1'b1;
      end else begin
        if (sym >= CH_A && sym <= CH_Z) begin
          legal = 1'b1;
          val = 5'(sym - CH_A);
        end else if (sym >= CH_2 && sym <= CH_7) begin
          legal = 1'b1;
          val = 5'(sym - CH_2 + 8'd26);
        end
        if (!legal || sh_pad) begin
          sh_err = ST_INVALID;
        end else begin
          nbuf = {sh_buf[6:0], val};
          ncnt = {1'b0, sh_cnt} + 5'd5;
          if (ncnt >= 5'd8) begin
            ncnt = ncnt - 5'd8;
            if (sh_bytes >= 6'(MAX_DEC)) begin
              sh_err = ST_OVERFLOW;
            end else begin
              shifted = nbuf >> ncnt;
              if (sh_bytes < 6'(KEY_LEN)) begin
                r.byte_valid = 1'b1;
                r.key_byte   = shifted[7:0];
                r.byte_index = sh_bytes[4:0];
              end
              sh_bytes = sh_bytes + 6'd1;
            end
          end
          sh_buf = nbuf;
          sh_cnt = ncnt[3:0];
        end
      end
    end
    r.status = sh_err;
    r.done_res = lst;
    if (lst) begin
      if (sh_err == ST_OK && sh_bytes < 6'(KEY_LEN)) r.status = ST_SHORT;
      sh_buf = '0;
      sh_cnt = '0;
      sh_bytes = '0;
      sh_pad = 1'b0;
      sh_err = ST_OK;
    end
  endtask

  task automatic push_char(input logic [7:0] sym, input logic lst);
    char_item_t it;
    it.sym = sym;
    it.last = lst;
    char_queue.push_back(it);
    phase_items++;
  endtask

  function automatic logic [7:0] rand_b32();
    int v;
    v = $urandom_range(0, 31);
    return (v < 26) ? 8'(CH_A + v) : 8'(CH_2 + v - 26);
  endfunction

  // One address string: mostly well formed, some short, long, broken or noise
  task automatic push_address();
    logic [7:0] syms[$];
    int kind;
    int n;
    int bad_pos;
    int i;
    logic empty_end;
    kind = $urandom_range(0, 99);
    empty_end = ($urandom_range(0, 3) == 0);
    n = 58;
    bad_pos = -1;
    if (kind < 45) begin
      n = 58;
    end else if (kind < 55) begin
      n = 56;
    end else if (kind < 65) begin
      n = $urandom_range(59, 64);
    end else if (kind < 75) begin
      n = $urandom_range(0, 55);
    end else if (kind < 88) begin
      n = 58;
      bad_pos = $urandom_range(0, 57);
    end else begin
      n = $urandom_range(1, 12);
    end
    for (i = 0; i < n; i++) begin
      if ($urandom_range(0, 39) == 0) syms.push_back(SYM_NONE);
      if (kind >= 88) syms.push_back(8'($urandom_range(0, 255)));
      else if (i == bad_pos) begin
        syms.push_back(($urandom_range(0, 2) == 0) ? PAD_CHAR : 8'($urandom_range(0, 255)));
      end else syms.push_back(rand_b32());
    end
    // padded form ends in one to four pads
    if (kind >= 45 && kind < 55) begin
      n = $urandom_range(1, 4);
      for (i = 0; i < n; i++) syms.push_back(PAD_CHAR);
    end
    if (syms.size() == 0) empty_end = 1'b1;
    for (i = 0; i < syms.size(); i++) begin
      push_char(syms[i], !empty_end && (i == syms.size() - 1));
    end
    if (empty_end) push_char(SYM_NONE, 1'b1);
  endtask

  task automatic wait_drained();
    while (char_queue.size() != 0 || decoded_queue.size() != 0) @(negedge clk);
  endtask

  // Driver: offer the head of the character queue, predict on acceptance
  always @(posedge clk) begin : driver
    dec_result_t r;
    logic offer;
    int pct;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        decode_char(s_tdata, s_tlast, r);
        decoded_queue.push_back(r);
        void'(char_queue.pop_front());
        chars_taken <= chars_taken + 1;
      end
      pct = (idle_mode == IDLE_SENDER) ? 47 : (idle_mode == IDLE_BOTH) ? 9 : 0;
      offer = 1'b0;
      if (char_queue.size() != 0) begin
        if (s_tvalid && !s_tready) offer = 1'b1;  // hold until taken
        else offer = ($urandom_range(0, 99) >= pct);
      end
      s_tvalid <= offer;
      if (offer) begin
        s_tdata <= char_queue[0].sym;
        s_tlast <= char_queue[0].last;
      end
    end
  end

  // Monitor: compare each result with the oldest prediction
  always @(posedge clk) begin : monitor
    dec_result_t want;
    int pct;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (decoded_queue.size() == 0) begin
          log_failure($sformatf("unexpected result tdata=%04h tlast=%0d", m_tdata, m_tlast));
        end else begin
          want = decoded_queue.pop_front();
          if (m_tdata[0] !== want.byte_valid || m_tdata[8:1] !== want.key_byte ||
              m_tdata[13:9] !== want.byte_index || m_tdata[15:14] !== want.status ||
              m_tlast !== want.done_res) begin
            log_failure($sformatf(
              "exp bv=%0d b=%02h i=%0d st=%0d d=%0d, got bv=%0d b=%02h i=%0d st=%0d d=%0d",
              want.byte_valid, want.key_byte, want.byte_index, want.status, want.done_res,
              m_tdata[0], m_tdata[8:1], m_tdata[13:9], m_tdata[15:14], m_tlast));
          end
        end
      end
      pct = (idle_mode == IDLE_RECV) ? 47 : (idle_mode == IDLE_BOTH) ? 9 : 0;
      m_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= pct);
    end
  end

  // Long receiver hold-off once, early in the run, so the input side backs up
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && chars_taken >= 40) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Watchdog on cycles where no item moves on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int ph;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty end, alphabet extremes, pads, foreign bytes, zero mid-stream
    push_char(SYM_NONE, 1'b1);
    push_char(CH_A, 1'b0);
    push_char(CH_Z, 1'b0);
    push_char(CH_2, 1'b0);
    push_char(CH_7, 1'b0);
    push_char(PAD_CHAR, 1'b1);
    push_char(PAD_CHAR, 1'b0);
    push_char("B", 1'b1);
    push_char(8'hFF, 1'b1);
    push_char("C", 1'b0);
    push_char(SYM_NONE, 1'b0);
    push_char("D", 1'b1);
    push_char("1", 1'b0);
    push_char("Q", 1'b1);
    push_char("8", 1'b1);
    push_char("@", 1'b1);
    push_char("[", 1'b1);
    push_char(8'h80, 1'b1);
    wait_drained();

    // Random addresses, one idle mode per phase
    for (ph = 0; ph < 4; ph++) begin
      idle_mode = idle_mode_t'(ph);
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) push_address();
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ filelist.f @@
rtl/b32kd_pkg.sv
rtl/b32kd_step.sv
rtl/base32_key_decoder.sv
bench/testbench.sv
